// ===== sv/frq_pkg.sv =====
// Package for the ready queue: command and status codes, item structs,
// and the default sizes that the top level hands down.
// No dependencies.
package frq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_BITS     = 8;

    localparam int CMD_W    = 2;
    localparam int TID_W    = 8;
    localparam int STATUS_W = 2;
    localparam int QCOUNT_W = 5;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_YIELD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TERM  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [TID_W-1:0] thread_id;
    } t_in_item;

    typedef struct packed {
        logic [TID_W-1:0]    next_thread;
        logic [STATUS_W-1:0] status;
        logic [QCOUNT_W-1:0] queued_count;
    } t_out_item;

endpackage

// ===== sv/frq_ram.sv =====
// Simple dual-port RAM holding the queued thread identifiers.
// One write port and one read port with registered read data. No dependencies.
module frq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/fifo_ready_queue_with_remove_unit.sv =====
// Ready queue of thread identifiers: sequencer, pointers and output register.
// Depends on frq_pkg and frq_ram.
//
// Usage: an input item carries a command (add at tail, yield the head, or
// terminate an identifier) and a thread identifier. Each item gives exactly
// one result item with the popped identifier, a status and the new count.
// The queue is a circular buffer in a RAM with one read and one write port;
// a small sequencer walks it one entry at a time through a single comparator.
// The input channel stalls from acceptance until the result is handed to the
// output register, so one item is in work at a time.
// Steps to the result: an add, an unused command or an empty or full case
// finish in the execute step; a yield reads the head from the RAM, then pops.
// A terminate reads and compares each entry up to the match, reads and writes
// each entry behind it to move it up, and then drops the tail; if not found
// it ends at the last compare. The next item is taken the cycle after the
// result is loaded, while that result may still wait.
// Reset empties the queue at once: count and head clear, no clearing pass,
// and RAM entries are only read after they were written.
// When the receiver stalls, the result holds in the output register; a
// finished item waits for the register to free before the next is accepted.
module fifo_ready_queue_with_remove_unit import frq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = PTR_W + 1;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_POP  = 3'd2;
    localparam logic [2:0] S_SRD  = 3'd3;
    localparam logic [2:0] S_SCMP = 3'd4;
    localparam logic [2:0] S_SHRD = 3'd5;
    localparam logic [2:0] S_SHWR = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]          r_state, n_state;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [ID_BITS-1:0]  r_id, n_id;
    logic [PTR_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [PTR_W-1:0]    r_ptr, n_ptr;
    logic [PTR_W-1:0]    r_k, n_k;
    logic [TID_W-1:0]    r_res_next, n_res_next;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out_item, n_out_item;

    logic               w_fin;
    logic               w_we;
    logic [PTR_W-1:0]   w_waddr;
    logic [ID_BITS-1:0] w_wdata;
    logic [PTR_W-1:0]   w_raddr;
    logic [ID_BITS-1:0] w_rdata;
    logic [SUM_W-1:0]   w_sum;
    logic [PTR_W-1:0]   w_tail;
    logic               w_k_last;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    frq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ID_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Tail position: head plus count, wrapped once around the buffer.
    assign w_sum    = SUM_W'(r_head) + SUM_W'(r_count);
    assign w_tail   = (w_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      PTR_W'(w_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(w_sum);
    assign w_k_last = ((CNT_W'(r_k) + CNT_W'(1)) == r_count);

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_id         = r_id;
        n_head       = r_head;
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_k          = r_k;
        n_res_next   = r_res_next;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_item   = r_out_item;
        w_fin        = 1'b0;
        w_we         = 1'b0;
        w_waddr      = r_ptr;
        w_wdata      = r_id;
        w_raddr      = r_ptr;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_item.cmd;
                    n_id    = ID_BITS'(i_in_item.thread_id);
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_ADD: begin
                        w_fin = 1'b1;
                        if (r_count == FULL_COUNT) begin
                            n_res_status = ST_FULL;
                        end else begin
                            w_we         = 1'b1;
                            w_waddr      = w_tail;
                            n_count      = r_count + CNT_W'(1);
                            n_res_status = ST_OK;
                        end
                    end
                    CMD_YIELD: begin
                        if (r_count == '0) begin
                            w_fin        = 1'b1;
                            n_res_status = ST_EMPTY;
                        end else begin
                            w_raddr = r_head;
                            n_state = S_POP;
                        end
                    end
                    CMD_TERM: begin
                        if (r_count == '0) begin
                            w_fin        = 1'b1;
                            n_res_status = ST_EMPTY;
                        end else begin
                            n_ptr   = r_head;
                            n_k     = '0;
                            n_state = S_SRD;
                        end
                    end
                    default: begin
                        w_fin        = 1'b1;
                        n_res_status = ST_OK;
                    end
                endcase
            end
            S_POP: begin
                w_fin        = 1'b1;
                n_res_next   = TID_W'(w_rdata);
                n_res_status = ST_OK;
                n_head       = ptr_inc(r_head);
                n_count      = r_count - CNT_W'(1);
            end
            S_SRD: begin
                w_raddr = r_ptr;
                n_state = S_SCMP;
            end
            S_SCMP: begin
                if (w_rdata == r_id) begin
                    n_state = S_SHRD;
                end else if (w_k_last) begin
                    w_fin        = 1'b1;
                    n_res_status = ST_NOT_FOUND;
                end else begin
                    n_ptr   = ptr_inc(r_ptr);
                    n_k     = r_k + PTR_W'(1);
                    n_state = S_SRD;
                end
            end
            S_SHRD: begin
                // Once the last queued entry is reached, dropping the tail
                // by one closes the gap.
                if (w_k_last) begin
                    w_fin        = 1'b1;
                    n_res_status = ST_OK;
                    n_count      = r_count - CNT_W'(1);
                end else begin
                    w_raddr = ptr_inc(r_ptr);
                    n_state = S_SHWR;
                end
            end
            S_SHWR: begin
                w_we    = 1'b1;
                w_waddr = r_ptr;
                w_wdata = w_rdata;
                n_ptr   = ptr_inc(r_ptr);
                n_k     = r_k + PTR_W'(1);
                n_state = S_SHRD;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid             = 1'b1;
                    n_out_item.next_thread  = r_res_next;
                    n_out_item.status       = r_res_status;
                    n_out_item.queued_count = QCOUNT_W'(r_count);
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_fin) begin
            n_state = S_DONE;
            if (r_state != S_POP) begin
                n_res_next = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_id         <= n_id;
        r_ptr        <= n_ptr;
        r_k          <= n_k;
        r_res_next   <= n_res_next;
        r_res_status <= n_res_status;
        r_out_item   <= n_out_item;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("queue count exceeds depth");

    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin && n_res_status == ST_FULL) |-> (r_count == FULL_COUNT))
        else $error("full status reported on a queue with room");

    a_count_changes_at_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fin |=> (r_count == $past(r_count)))
        else $error("count changed outside the finishing step");

    a_search_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCMP || r_state == S_SHRD) |-> (CNT_W'(r_k) < r_count))
        else $error("search position beyond queued entries");
`endif

endmodule

// ===== tb/frq_checker.sv =====
// Checker for the ready queue: watches both channels, predicts each result
// from its own copy of the queue, and compares it with what the block hands out.
// Depends on frq_pkg.
`timescale 1ns / 1ps

module frq_checker import frq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    output int        o_err_count,
    output int        o_pending
);

    logic [TID_W-1:0] run_list[$];
    t_out_item        sched_expect[$];
    t_out_item        want;
    t_out_item        got;
    int               mismatch_count = 0;

    assign o_err_count = mismatch_count;

    // Applies one command to the shadow queue and builds the result it gives.
    task automatic predict_sched_result(input t_in_item it, output t_out_item res);
        bit hit;
        hit = 1'b0;
        res = '0;
        res.status = ST_OK;
        case (it.cmd)
            CMD_ADD: begin
                if (run_list.size() >= DEF_QUEUE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    run_list.push_back(it.thread_id);
                end
            end
            CMD_YIELD: begin
                if (run_list.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.next_thread = run_list.pop_front();
                end
            end
            CMD_TERM: begin
                if (run_list.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.status = ST_NOT_FOUND;
                    // Only the oldest matching entry goes away.
                    for (int i = 0; i < run_list.size() && !hit; i++) begin
                        if (run_list[i] == it.thread_id) begin
                            run_list.delete(i);
                            res.status = ST_OK;
                            hit = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
        res.queued_count = QCOUNT_W'(run_list.size());
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            run_list.delete();
            sched_expect.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = i_out_item;
                if (sched_expect.size() == 0) begin
                    $error("result item with no expectation: next_thread %0d status %0d count %0d",
                           got.next_thread, got.status, got.queued_count);
                    mismatch_count++;
                end else begin
                    want = sched_expect.pop_front();
                    if (got.next_thread !== want.next_thread) begin
                        $error("next_thread: expected %0d, actual %0d",
                               want.next_thread, got.next_thread);
                        mismatch_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        mismatch_count++;
                    end
                    if (got.queued_count !== want.queued_count) begin
                        $error("queued_count: expected %0d, actual %0d",
                               want.queued_count, got.queued_count);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_sched_result(i_in_item, want);
                sched_expect.push_back(want);
            end
            o_pending <= sched_expect.size();
        end
    end

endmodule

// ===== tb/tb_fifo_ready_queue_with_remove_unit.sv =====
// Top of the ready queue testbench: clock, reset, stimulus and verdict.
// Depends on frq_pkg, fifo_ready_queue_with_remove_unit and frq_checker.
`timescale 1ns / 1ps

module tb_fifo_ready_queue_with_remove_unit;
    import frq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 267;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;
    logic      out_stall = 1'b0;

    int        err_count;
    int        pending;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        add_pct = 50;

    fifo_ready_queue_with_remove_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall)
    );

    frq_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TID_W-1:0] tid);
        in_valid <= 1'b1;
        in_item.cmd <= cmd;
        in_item.thread_id <= tid;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic sender_gap();
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            in_item <= t_in_item'($urandom);
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Holds the sender off until every outstanding result has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Small identifier pool so that terminates find matches and duplicates
    // appear; the full range now and then so every bit toggles.
    function automatic logic [TID_W-1:0] pick_thread_id();
        if ($urandom_range(3) == 0) begin
            return TID_W'($urandom_range(255));
        end
        return TID_W'($urandom_range(15));
    endfunction

    task automatic send_random_item();
        int roll;
        logic [CMD_W-1:0] cmd;
        roll = $urandom_range(99);
        if (roll < 3) begin
            cmd = CMD_UNUSED;
        end else if (roll < add_pct) begin
            cmd = CMD_ADD;
        end else if (roll < add_pct + (100 - add_pct) / 2) begin
            cmd = CMD_TERM;
        end else begin
            cmd = CMD_YIELD;
        end
        send_item(cmd, pick_thread_id());
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty cases, duplicates, absent ids, a full queue.
        send_item(CMD_YIELD, 8'd0);
        send_item(CMD_TERM, 8'd7);
        send_item(CMD_UNUSED, 8'hFF);
        send_item(CMD_ADD, 8'd0);
        send_item(CMD_ADD, 8'd255);
        send_item(CMD_ADD, 8'hA5);
        send_item(CMD_ADD, 8'h5A);
        send_item(CMD_ADD, 8'hA5);
        send_item(CMD_TERM, 8'hA5);
        send_item(CMD_TERM, 8'h33);
        send_item(CMD_YIELD, 8'hFF);
        send_item(CMD_UNUSED, 8'h00);
        for (int k = 0; k < 12; k++) begin
            send_item(CMD_ADD, TID_W'(8'h10 + k));
        end
        send_item(CMD_ADD, 8'h77);
        send_item(CMD_ADD, 8'h78);
        send_item(CMD_TERM, 8'h1B);
        send_item(CMD_TERM, 8'h5A);
        drain_results();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 19;
                    recv_stall_pct = 74;
                end
                1: begin
                    send_idle_pct = 74;
                    recv_stall_pct = 19;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Swing between filling and draining so full and empty recur.
                if (n % 40 == 0) begin
                    case ($urandom_range(2))
                        0: add_pct = 75;
                        1: add_pct = 45;
                        default: add_pct = 20;
                    endcase
                end
                sender_gap();
                send_random_item();
            end
            drain_results();
        end

        recv_stall_pct = 0;
        repeat (80) @(posedge i_clk);
        if (err_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
